@@ hw/rtl/mbe_pkg.sv @@
// Shared constants, types and codes for the Mandelbrot escape-time unit.
package mbe_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 16;
  localparam int MAX_DIM    = 1024;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int SIZE_W    = COORD_W + 1;

  // Window mapping widths: span times coordinate, its magnitude, and c at full width.
  localparam int SPAN_W    = CFG_W + 1;
  localparam int PROD_W    = SPAN_W + COORD_W + 1;
  localparam int MAG_W     = PROD_W - 1;
  localparam int C_W       = PROD_W + 1;
  localparam int DIV_CNT_W = $clog2(MAG_W + 1);

  // Iteration widths: multiplier operand, exact product, and the z register.
  localparam int OPW  = FRAC_BITS + 3;
  localparam int MULW = 2 * OPW;
  localparam int Z_W  = (C_W > OPW + 2) ? C_W : OPW + 2;

  localparam logic signed [Z_W-1:0]  TWO_Z     = Z_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [Z_W-1:0]  NEG_TWO_Z = -TWO_Z;
  localparam logic signed [MULW-1:0] FOUR_SQ   = MULW'(1) << (2 * FRAC_BITS + 2);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_REAL_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

  localparam logic signed [CFG_W-1:0] RST_REAL_LOW  = CFG_W'(-(64'sd2 <<< FRAC_BITS));
  localparam logic signed [CFG_W-1:0] RST_REAL_HIGH = CFG_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [CFG_W-1:0] RST_IMAG_LOW  = CFG_W'(-(64'sd3 <<< (FRAC_BITS - 1)));
  localparam logic signed [CFG_W-1:0] RST_IMAG_HIGH = CFG_W'(64'sd3 <<< (FRAC_BITS - 1));
  localparam logic [SIZE_W-1:0]       RST_SIZE      = SIZE_W'(800);
  localparam logic [COUNT_BITS-1:0]   RST_LIMIT     = COUNT_BITS'(1000);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MAP_SET,
    S_IT_MUL,
    S_IT_ADD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic axis;
    logic map_mul;
    logic div_go;
    logic map_set;
    logic it_mul;
    logic it_upd;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic at_limit;
    logic escape;
  } stat_t;

endpackage

@@ hw/rtl/mbe_div.sv @@
// Restoring divider, one quotient bit per cycle, for the window mapping.
module mbe_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [mbe_pkg::MAG_W-1:0]  dividend,
  input  logic [mbe_pkg::SIZE_W-1:0] divisor,
  output logic                       done,
  output logic [mbe_pkg::MAG_W-1:0]  quotient
);

  logic [mbe_pkg::MAG_W-1:0]     quo_r, quo_nxt;
  logic [mbe_pkg::SIZE_W-1:0]    rem_r, rem_nxt;
  logic [mbe_pkg::SIZE_W-1:0]    dvs_r;
  logic [mbe_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [mbe_pkg::SIZE_W:0]      shifted;
  logic                          ge;

  always_comb begin
    shifted = {rem_r, quo_r[mbe_pkg::MAG_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    // The remainder stays below the divisor, so the low bits hold it.
    rem_nxt = ge ? mbe_pkg::SIZE_W'(shifted - {1'b0, dvs_r})
                 : shifted[mbe_pkg::SIZE_W-1:0];
    quo_nxt = {quo_r[mbe_pkg::MAG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= mbe_pkg::DIV_CNT_W'(mbe_pkg::MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mbe_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_go_starts: assert property (@(posedge clk) disable iff (!rst_n) go |=> busy_r)
    else $error("divider did not start on go");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider signals done while still stepping");

endmodule

@@ hw/rtl/mbe_datapath.sv @@
// Datapath: configuration registers, window mapping and the complex iteration.
module mbe_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]      cfg_data,
  input  logic [mbe_pkg::COORD_W-1:0]    in_column,
  input  logic [mbe_pkg::COORD_W-1:0]    in_row,
  input  mbe_pkg::cmd_t                  cmd,
  output mbe_pkg::stat_t                 stat,
  output logic [mbe_pkg::COORD_W-1:0]    column_out,
  output logic [mbe_pkg::COORD_W-1:0]    row_out,
  output logic [mbe_pkg::COUNT_BITS-1:0] escape_count
);

  logic signed [mbe_pkg::CFG_W-1:0] real_low_r, real_high_r, imag_low_r, imag_high_r;
  logic [mbe_pkg::SIZE_W-1:0]       width_r, height_r;
  logic [mbe_pkg::COUNT_BITS-1:0]   limit_r;

  logic [mbe_pkg::COORD_W-1:0]      col_r, row_r;
  logic [mbe_pkg::COUNT_BITS-1:0]   count_r;
  logic signed [mbe_pkg::PROD_W-1:0] prod_r;
  logic signed [mbe_pkg::C_W-1:0]   cr_r, ci_r;
  logic signed [mbe_pkg::Z_W-1:0]   zr_r, zi_r;
  logic signed [mbe_pkg::MULW-1:0]  sr_r, si_r, pri_r;
  logic                             oor_r;

  logic signed [mbe_pkg::CFG_W-1:0]   lo_sel, hi_sel;
  logic [mbe_pkg::COORD_W-1:0]        coord;
  logic [mbe_pkg::SIZE_W-1:0]         size_sel, divisor;
  logic signed [mbe_pkg::SPAN_W-1:0]  span;
  logic signed [mbe_pkg::COORD_W:0]   coord_s;
  logic signed [mbe_pkg::PROD_W-1:0]  prod, quo_s;
  logic [mbe_pkg::MAG_W-1:0]          mag, quo;
  logic                               div_done;
  logic signed [mbe_pkg::C_W-1:0]     c_val;
  logic signed [mbe_pkg::OPW-1:0]     opr, opi;
  logic signed [mbe_pkg::MULW-1:0]    sum, diff, diff_sh, pri_sh;
  logic signed [mbe_pkg::Z_W-1:0]     zr_upd, zi_upd;
  logic                               z_oor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_low_r  <= mbe_pkg::RST_REAL_LOW;
      real_high_r <= mbe_pkg::RST_REAL_HIGH;
      imag_low_r  <= mbe_pkg::RST_IMAG_LOW;
      imag_high_r <= mbe_pkg::RST_IMAG_HIGH;
      width_r     <= mbe_pkg::RST_SIZE;
      height_r    <= mbe_pkg::RST_SIZE;
      limit_r     <= mbe_pkg::RST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::REG_REAL_LOW:   real_low_r  <= $signed(cfg_data);
        mbe_pkg::REG_REAL_HIGH:  real_high_r <= $signed(cfg_data);
        mbe_pkg::REG_IMAG_LOW:   imag_low_r  <= $signed(cfg_data);
        mbe_pkg::REG_IMAG_HIGH:  imag_high_r <= $signed(cfg_data);
        mbe_pkg::REG_WIDTH:      width_r     <= cfg_data[mbe_pkg::SIZE_W-1:0];
        mbe_pkg::REG_HEIGHT:     height_r    <= cfg_data[mbe_pkg::SIZE_W-1:0];
        mbe_pkg::REG_ITER_LIMIT: limit_r     <= cfg_data[mbe_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window mapping for the axis that the controller selects.
  always_comb begin
    lo_sel   = cmd.axis ? imag_low_r  : real_low_r;
    hi_sel   = cmd.axis ? imag_high_r : real_high_r;
    coord    = cmd.axis ? row_r       : col_r;
    size_sel = cmd.axis ? height_r    : width_r;
    // A size of zero divides as one.
    divisor  = (size_sel == '0) ? mbe_pkg::SIZE_W'(1) : size_sel;
    span     = mbe_pkg::SPAN_W'(hi_sel) - mbe_pkg::SPAN_W'(lo_sel);
    coord_s  = $signed({1'b0, coord});
    prod     = span * coord_s;
    mag      = prod_r[mbe_pkg::PROD_W-1] ? mbe_pkg::MAG_W'(-prod_r)
                                         : mbe_pkg::MAG_W'(prod_r);
    // Division truncates toward zero, so the sign goes back on the magnitude.
    quo_s    = prod_r[mbe_pkg::PROD_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    c_val    = mbe_pkg::C_W'(lo_sel) + mbe_pkg::C_W'(quo_s);
  end

  mbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (mag),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // One complex step: products are registered on it_mul, the test and update follow on it_upd.
  always_comb begin
    opr     = zr_r[mbe_pkg::OPW-1:0];
    opi     = zi_r[mbe_pkg::OPW-1:0];
    z_oor   = (zr_r > mbe_pkg::TWO_Z) || (zr_r < mbe_pkg::NEG_TWO_Z) ||
              (zi_r > mbe_pkg::TWO_Z) || (zi_r < mbe_pkg::NEG_TWO_Z);
    sum     = sr_r + si_r;
    diff    = sr_r - si_r;
    diff_sh = diff >>> mbe_pkg::FRAC_BITS;
    // Doubling the cross product and shifting by the fraction is one shift less.
    pri_sh  = pri_r >>> (mbe_pkg::FRAC_BITS - 1);
    zr_upd  = mbe_pkg::Z_W'(diff_sh) + mbe_pkg::Z_W'(cr_r);
    zi_upd  = mbe_pkg::Z_W'(pri_sh) + mbe_pkg::Z_W'(ci_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_column;
      row_r <= in_row;
    end
    if (cmd.map_mul) begin
      prod_r <= prod;
    end
    if (cmd.map_set) begin
      if (cmd.axis) begin
        ci_r    <= c_val;
        zr_r    <= mbe_pkg::Z_W'(cr_r);
        zi_r    <= mbe_pkg::Z_W'(c_val);
        count_r <= '0;
      end else begin
        cr_r <= c_val;
      end
    end
    if (cmd.it_mul) begin
      oor_r <= z_oor;
      sr_r  <= opr * opr;
      si_r  <= opi * opi;
      pri_r <= opr * opi;
    end
    if (cmd.it_upd) begin
      zr_r    <= zr_upd;
      zi_r    <= zi_upd;
      count_r <= count_r + 1'b1;
    end
  end

  assign stat.div_done = div_done;
  assign stat.at_limit = (count_r == limit_r);
  assign stat.escape   = oor_r || (sum > mbe_pkg::FOUR_SQ);

  assign column_out   = col_r;
  assign row_out      = row_r;
  assign escape_count = count_r;

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.it_upd |=> count_r == $past(count_r) + 1'b1)
    else $error("iteration count did not advance by one on an update");

endmodule

@@ hw/rtl/mbe_ctrl.sv @@
// Controller: sequences mapping of both axes, the iteration loop and the result beat.
module mbe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mbe_pkg::stat_t stat,
  output mbe_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid
);

  mbe_pkg::state_t state_r, state_nxt;
  logic            axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbe_pkg::S_IDLE;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      mbe_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = mbe_pkg::S_MAP_MUL;
          axis_nxt  = 1'b0;
        end
      end
      mbe_pkg::S_MAP_MUL:  state_nxt = mbe_pkg::S_DIV_GO;
      mbe_pkg::S_DIV_GO:   state_nxt = mbe_pkg::S_DIV_WAIT;
      mbe_pkg::S_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = mbe_pkg::S_MAP_SET;
        end
      end
      mbe_pkg::S_MAP_SET: begin
        if (axis_r) begin
          state_nxt = mbe_pkg::S_IT_MUL;
        end else begin
          state_nxt = mbe_pkg::S_MAP_MUL;
          axis_nxt  = 1'b1;
        end
      end
      mbe_pkg::S_IT_MUL: begin
        state_nxt = stat.at_limit ? mbe_pkg::S_DONE : mbe_pkg::S_IT_ADD;
      end
      mbe_pkg::S_IT_ADD: begin
        state_nxt = stat.escape ? mbe_pkg::S_DONE : mbe_pkg::S_IT_MUL;
      end
      mbe_pkg::S_DONE:     state_nxt = mbe_pkg::S_IDLE;
      default:             state_nxt = mbe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.axis  = axis_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      mbe_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mbe_pkg::S_MAP_MUL:  cmd.map_mul = 1'b1;
      mbe_pkg::S_DIV_GO:   cmd.div_go  = 1'b1;
      mbe_pkg::S_DIV_WAIT: ;
      mbe_pkg::S_MAP_SET:  cmd.map_set = stat.div_done || 1'b1;
      mbe_pkg::S_IT_MUL:   cmd.it_mul  = !stat.at_limit;
      mbe_pkg::S_IT_ADD:   cmd.it_upd  = !stat.escape;
      mbe_pkg::S_DONE:     out_valid   = 1'b1;
      default:             busy        = 1'b0;
    endcase
  end

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted pixel did not make the unit busy");

endmodule

@@ hw/rtl/mandelbrot_escape_time_unit.sv @@
// Top level of the Mandelbrot escape-time unit.
// From an accepted start, the unit maps the real axis, then the imaginary axis; each
// mapping spends most of its time in the one-bit-per-cycle divider. Each iteration
// registers the products, then tests for escape and updates z, until escape or the limit.
// A new pixel is taken only once busy drops after the out_valid beat.
// Synchronous reset loads the default window and limit; the unit then idles.
module mandelbrot_escape_time_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mbe_pkg::COORD_W-1:0]    in_column,
  input  logic [mbe_pkg::COORD_W-1:0]    in_row,
  output logic                           out_valid,
  output logic [mbe_pkg::COORD_W-1:0]    out_column_out,
  output logic [mbe_pkg::COORD_W-1:0]    out_row_out,
  output logic [mbe_pkg::COUNT_BITS-1:0] out_escape_count,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]      cfg_data
);

  mbe_pkg::cmd_t  cmd;
  mbe_pkg::stat_t stat;

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mbe_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_column    (in_column),
    .in_row       (in_row),
    .cmd          (cmd),
    .stat         (stat),
    .column_out   (out_column_out),
    .row_out      (out_row_out),
    .escape_count (out_escape_count)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Mandelbrot escape-time unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_W    = mbe_pkg::COORD_W;
  localparam int COUNT_BITS = mbe_pkg::COUNT_BITS;
  localparam int CFG_W      = mbe_pkg::CFG_W;
  localparam int CFG_IDX_W  = mbe_pkg::CFG_IDX_W;
  localparam int SIZE_W     = mbe_pkg::SIZE_W;
  localparam int FRAC_BITS  = mbe_pkg::FRAC_BITS;
  localparam int MAX_DIM    = mbe_pkg::MAX_DIM;

  localparam int DIRECTED_ROWS = 19;
  localparam int RANDOM_ITEMS  = 600;
  localparam int QUIET_LIMIT   = 500000;
  localparam int TAIL_CYCLES   = 200;

  typedef enum logic [2:0] {
    SETUP_KEEP,
    SETUP_NO_ITER,
    SETUP_ONE_ITER,
    SETUP_FULL_RANGE,
    SETUP_ZERO_SIZE,
    SETUP_OVERSIZE,
    SETUP_FLAT_LONG
  } setup_t;

  typedef struct packed {
    setup_t              setup;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic                known;
    logic [COUNT_BITS-1:0] count;
  } pixel_case_t;

  typedef struct packed {
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
    logic [COUNT_BITS-1:0] count;
  } pixel_result_t;

  // Rows marked known carry a count that follows directly from the window.
  localparam pixel_case_t DIRECTED [DIRECTED_ROWS] = '{
    '{SETUP_KEEP,       10'd0,    10'd400,  1'b1, 16'd1000},
    '{SETUP_KEEP,       10'd1023, 10'd1023, 1'b0, 16'd0},
    '{SETUP_KEEP,       10'd0,    10'd0,    1'b0, 16'd0},
    '{SETUP_KEEP,       10'd400,  10'd400,  1'b0, 16'd0},
    '{SETUP_NO_ITER,    10'd512,  10'd512,  1'b1, 16'd0},
    '{SETUP_KEEP,       10'd0,    10'd400,  1'b1, 16'd0},
    '{SETUP_ONE_ITER,   10'd0,    10'd400,  1'b1, 16'd1},
    '{SETUP_KEEP,       10'd1023, 10'd0,    1'b0, 16'd0},
    '{SETUP_FULL_RANGE, 10'd0,    10'd512,  1'b1, 16'd0},
    '{SETUP_KEEP,       10'd512,  10'd512,  1'b0, 16'd0},
    '{SETUP_KEEP,       10'd1023, 10'd1023, 1'b0, 16'd0},
    '{SETUP_KEEP,       10'd1023, 10'd0,    1'b0, 16'd0},
    '{SETUP_ZERO_SIZE,  10'd0,    10'd0,    1'b0, 16'd0},
    '{SETUP_KEEP,       10'd1,    10'd1,    1'b0, 16'd0},
    '{SETUP_KEEP,       10'd1023, 10'd1023, 1'b1, 16'd0},
    '{SETUP_OVERSIZE,   10'd1023, 10'd0,    1'b0, 16'd0},
    '{SETUP_KEEP,       10'd0,    10'd1023, 1'b1, 16'd0},
    '{SETUP_KEEP,       10'd700,  10'd1,    1'b0, 16'd0},
    '{SETUP_FLAT_LONG,  10'd1023, 10'd1023, 1'b1, 16'd65535}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_W-1:0]    in_column = '0;
  logic [COORD_W-1:0]    in_row = '0;
  logic                  out_valid;
  logic [COORD_W-1:0]    out_column_out;
  logic [COORD_W-1:0]    out_row_out;
  logic [COUNT_BITS-1:0] out_escape_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Shadow copy of the window and limit registers.
  longint      win_real_low, win_real_high, win_imag_low, win_imag_high;
  int unsigned win_width, win_height, win_limit;

  pixel_result_t pending_pixels [$];
  int          error_count = 0;
  int          pixels_sent = 0;
  int          pixels_checked = 0;
  int          windows_loaded = 0;
  int unsigned deepest_limit = 0;
  int          quiet_cycles = 0;

  mandelbrot_escape_time_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_column        (in_column),
    .in_row           (in_row),
    .out_valid        (out_valid),
    .out_column_out   (out_column_out),
    .out_row_out      (out_row_out),
    .out_escape_count (out_escape_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint axis_point(input longint lo, input longint hi,
                                        input logic [COORD_W-1:0] coord,
                                        input int unsigned size);
    longint span;
    longint divisor;
    longint pos;
    span = hi - lo;
    divisor = (size == 0) ? 64'sd1 : longint'(size);
    pos = longint'(coord);
    return lo + (span * pos) / divisor;
  endfunction

  function automatic logic [COUNT_BITS-1:0] escape_count_for(
      input logic [COORD_W-1:0] column, input logic [COORD_W-1:0] row);
    longint      cr, ci, zr, zi, sr, si, next_zi;
    longint      two, four_sq;
    int unsigned n;
    two = 64'sd2 <<< FRAC_BITS;
    four_sq = 64'sd4 <<< (2 * FRAC_BITS);
    cr = axis_point(win_real_low, win_real_high, column, win_width);
    ci = axis_point(win_imag_low, win_imag_high, row, win_height);
    zr = cr;
    zi = ci;
    for (n = 0; n < win_limit; n++) begin
      // A part beyond 2.0 escapes before the squares could grow too wide.
      if ((zr < 0 ? -zr : zr) > two || (zi < 0 ? -zi : zi) > two) break;
      sr = zr * zr;
      si = zi * zi;
      if (sr + si > four_sq) break;
      next_zi = ((64'sd2 * zr * zi) >>> FRAC_BITS) + ci;
      zr = ((sr - si) >>> FRAC_BITS) + cr;
      zi = next_zi;
    end
    return n[COUNT_BITS-1:0];
  endfunction

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      mbe_pkg::REG_REAL_LOW:   win_real_low = longint'($signed(value));
      mbe_pkg::REG_REAL_HIGH:  win_real_high = longint'($signed(value));
      mbe_pkg::REG_IMAG_LOW:   win_imag_low = longint'($signed(value));
      mbe_pkg::REG_IMAG_HIGH:  win_imag_high = longint'($signed(value));
      mbe_pkg::REG_WIDTH:      win_width = 32'(value[SIZE_W-1:0]);
      mbe_pkg::REG_HEIGHT:     win_height = 32'(value[SIZE_W-1:0]);
      mbe_pkg::REG_ITER_LIMIT: win_limit = 32'(value[COUNT_BITS-1:0]);
      default: ;
    endcase
  endtask

  task automatic wait_all_done();
    start <= 1'b0;
    while (pending_pixels.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic load_window(input logic [CFG_W-1:0] real_low,
                             input logic [CFG_W-1:0] real_high,
                             input logic [CFG_W-1:0] imag_low,
                             input logic [CFG_W-1:0] imag_high,
                             input int unsigned width, input int unsigned height,
                             input int unsigned limit);
    wait_all_done();
    write_reg(mbe_pkg::REG_REAL_LOW, real_low);
    write_reg(mbe_pkg::REG_REAL_HIGH, real_high);
    write_reg(mbe_pkg::REG_IMAG_LOW, imag_low);
    write_reg(mbe_pkg::REG_IMAG_HIGH, imag_high);
    write_reg(mbe_pkg::REG_WIDTH, CFG_W'(width));
    write_reg(mbe_pkg::REG_HEIGHT, CFG_W'(height));
    write_reg(mbe_pkg::REG_ITER_LIMIT, CFG_W'(limit));
    cfg_we <= 1'b0;
    windows_loaded++;
    if (limit > deepest_limit) deepest_limit = limit;
  endtask

  // Start stays high on return so that back-to-back pixels need no extra edge.
  task automatic send_pixel(input logic [COORD_W-1:0] column, input logic [COORD_W-1:0] row,
                            input logic known, input logic [COUNT_BITS-1:0] count);
    pixel_result_t want;
    want.column = column;
    want.row = row;
    want.count = known ? count : escape_count_for(column, row);
    start <= 1'b1;
    in_column <= column;
    in_row <= row;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(want);
    pixels_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic apply_setup(input setup_t setup);
    case (setup)
      SETUP_NO_ITER:
        load_window(mbe_pkg::RST_REAL_LOW, mbe_pkg::RST_REAL_HIGH,
                    mbe_pkg::RST_IMAG_LOW, mbe_pkg::RST_IMAG_HIGH, 800, 800, 0);
      SETUP_ONE_ITER:
        load_window(mbe_pkg::RST_REAL_LOW, mbe_pkg::RST_REAL_HIGH,
                    mbe_pkg::RST_IMAG_LOW, mbe_pkg::RST_IMAG_HIGH, 800, 800, 1);
      SETUP_FULL_RANGE:
        load_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1024, 1024, 50);
      SETUP_ZERO_SIZE:
        load_window(mbe_pkg::RST_REAL_LOW, mbe_pkg::RST_REAL_HIGH,
                    mbe_pkg::RST_IMAG_LOW, mbe_pkg::RST_IMAG_HIGH, 0, 0, 40);
      SETUP_OVERSIZE:
        // Inverted real axis, width past the coordinate range, a single row.
        load_window(32'h1000_0000, 32'hE000_0000,
                    mbe_pkg::RST_IMAG_LOW, mbe_pkg::RST_IMAG_HIGH, 2047, 1, 64);
      SETUP_FLAT_LONG:
        load_window('0, '0, '0, '0, 1, 1, 65535);
      default: ;
    endcase
  endtask

  task automatic random_window();
    longint      rl, rh, il, ih, swap;
    int unsigned w, h, limit, pick;
    if ($urandom_range(0, 9) < 7) begin
      // Windows around the set, where the counts spread out.
      rl = -longint'($urandom_range(32'h1000_0000, 32'h2800_0000));
      rh = rl + longint'($urandom_range(32'h0010_0000, 32'h3000_0000));
      il = -longint'($urandom_range(0, 32'h1800_0000));
      ih = il + longint'($urandom_range(32'h0010_0000, 32'h3000_0000));
      if ($urandom_range(0, 4) == 0) begin
        swap = rl;
        rl = rh;
        rh = swap;
      end
    end else begin
      rl = longint'($signed($urandom));
      rh = longint'($signed($urandom));
      il = longint'($signed($urandom));
      ih = longint'($signed($urandom));
    end
    w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
    h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
    pick = $urandom_range(0, 99);
    if (pick < 3) limit = 0;
    else if (pick < 70) limit = $urandom_range(1, 64);
    else if (pick < 95) limit = $urandom_range(65, 600);
    else limit = $urandom_range(601, 3000);
    load_window(rl[CFG_W-1:0], rh[CFG_W-1:0], il[CFG_W-1:0], ih[CFG_W-1:0], w, h, limit);
  endtask

  task automatic random_phase(input int items);
    int                 burst_left;
    logic               bursty;
    int unsigned        span_cols, span_rows;
    logic [COORD_W-1:0] column, row;
    random_window();
    bursty = ($urandom_range(0, 3) != 0);
    burst_left = $urandom_range(1, 12);
    span_cols = (win_width > MAX_DIM) ? MAX_DIM : win_width;
    span_rows = (win_height > MAX_DIM) ? MAX_DIM : win_height;
    repeat (items) begin
      if (span_cols == 0 || $urandom_range(0, 4) == 0) column = COORD_W'($urandom);
      else column = COORD_W'($urandom_range(0, span_cols - 1));
      if (span_rows == 0 || $urandom_range(0, 4) == 0) row = COORD_W'($urandom);
      else row = COORD_W'($urandom_range(0, span_rows - 1));
      send_pixel(column, row, 1'b0, '0);
      if ($urandom_range(0, 39) == 0) begin
        wait_all_done();
      end else if (bursty) begin
        burst_left--;
        if (burst_left == 0) begin
          pause_sender($urandom_range(1, 300));
          burst_left = $urandom_range(1, 12);
        end
      end
    end
  endtask

  // Result checker and watchdog.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid) begin
        if (pending_pixels.size() == 0) begin
          $error("result beat with nothing expected: column %0d row %0d count %0d",
                 out_column_out, out_row_out, out_escape_count);
          error_count++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (out_column_out !== want.column) begin
            $error("column_out: expected %0d, got %0d", want.column, out_column_out);
            error_count++;
          end
          if (out_row_out !== want.row) begin
            $error("row_out: expected %0d, got %0d", want.row, out_row_out);
            error_count++;
          end
          if (out_escape_count !== want.count) begin
            $error("escape_count: expected %0d, got %0d", want.count, out_escape_count);
            error_count++;
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_pixels.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    win_real_low = longint'(mbe_pkg::RST_REAL_LOW);
    win_real_high = longint'(mbe_pkg::RST_REAL_HIGH);
    win_imag_low = longint'(mbe_pkg::RST_IMAG_LOW);
    win_imag_high = longint'(mbe_pkg::RST_IMAG_HIGH);
    win_width = 32'(mbe_pkg::RST_SIZE);
    win_height = 32'(mbe_pkg::RST_SIZE);
    win_limit = 32'(mbe_pkg::RST_LIMIT);
    deepest_limit = 32'(mbe_pkg::RST_LIMIT);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      apply_setup(DIRECTED[i].setup);
      send_pixel(DIRECTED[i].column, DIRECTED[i].row, DIRECTED[i].known, DIRECTED[i].count);
    end

    while (pixels_sent < DIRECTED_ROWS + RANDOM_ITEMS) random_phase($urandom_range(20, 70));

    wait_all_done();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d pixels across %0d window settings.",
             pixels_checked, pixels_sent, windows_loaded);
    $display("Iteration limits from 0 up to %0d, window edges over the full Q4.28 range.",
             deepest_limit);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_div.sv
hw/rtl/mbe_datapath.sv
hw/rtl/mbe_ctrl.sv
hw/rtl/mandelbrot_escape_time_unit.sv
tb/tb_top.sv
